// ----- rtl/core/ptpd_pkg.sv -----
// Shared types and fixed widths for the point-to-plane distance block.
package ptpd_pkg;

	localparam int FIELD_W = 16;
	localparam int DIST_W  = 25;
	localparam int NUM_COORDS = 12;

	typedef struct packed {
		logic signed [FIELD_W-1:0] plane_p0_x;
		logic signed [FIELD_W-1:0] plane_p0_y;
		logic signed [FIELD_W-1:0] plane_p0_z;
		logic signed [FIELD_W-1:0] plane_p1_x;
		logic signed [FIELD_W-1:0] plane_p1_y;
		logic signed [FIELD_W-1:0] plane_p1_z;
		logic signed [FIELD_W-1:0] plane_p2_x;
		logic signed [FIELD_W-1:0] plane_p2_y;
		logic signed [FIELD_W-1:0] plane_p2_z;
		logic signed [FIELD_W-1:0] query_x;
		logic signed [FIELD_W-1:0] query_y;
		logic signed [FIELD_W-1:0] query_z;
	} ptpd_in_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance_fixed;
		logic              degenerate;
	} ptpd_out_t;

endpackage

// ----- rtl/core/ptpd_front.sv -----
// Front pipeline: edge vectors, normal, plane numerator, squared terms.
module ptpd_front #(
	parameter int CW   = 16,
	parameter int FRAC = 8,
	parameter int SW   = 68,
	parameter int RW   = 121
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               query_valid,
	output logic               query_ready,
	input  ptpd_pkg::ptpd_in_t query,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [RW-1:0]      out_r,
	output logic [SW-1:0]      out_s,
	output logic               out_degen
);

	localparam int XW   = (CW > ptpd_pkg::FIELD_W) ? CW : ptpd_pkg::FIELD_W;
	localparam int EW   = CW + 1;
	localparam int NW   = 2 * CW + 2;
	localparam int MW   = NW - 1;
	localparam int H    = (MW + 1) / 2;
	localparam int HW   = MW - H;
	localparam int PW   = NW + EW;
	localparam int NUMW = PW + 2;
	localparam int AW   = NUMW - 1;
	localparam int AH   = (AW + 1) / 2;
	localparam int AHW  = AW - AH;
	localparam int TW   = 2 * AW + 2 * FRAC;

	logic [XW-1:0]         raw [ptpd_pkg::NUM_COORDS];
	logic signed [CW-1:0]  c   [ptpd_pkg::NUM_COORDS];

	assign raw[0]  = XW'($unsigned(query.plane_p0_x));
	assign raw[1]  = XW'($unsigned(query.plane_p0_y));
	assign raw[2]  = XW'($unsigned(query.plane_p0_z));
	assign raw[3]  = XW'($unsigned(query.plane_p1_x));
	assign raw[4]  = XW'($unsigned(query.plane_p1_y));
	assign raw[5]  = XW'($unsigned(query.plane_p1_z));
	assign raw[6]  = XW'($unsigned(query.plane_p2_x));
	assign raw[7]  = XW'($unsigned(query.plane_p2_y));
	assign raw[8]  = XW'($unsigned(query.plane_p2_z));
	assign raw[9]  = XW'($unsigned(query.query_x));
	assign raw[10] = XW'($unsigned(query.query_y));
	assign raw[11] = XW'($unsigned(query.query_z));

	always_comb begin
		for (int i = 0; i < ptpd_pkg::NUM_COORDS; i++) begin
			c[i] = signed'(raw[i][CW-1:0]);
		end
	end

	// stage valids and ready chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	assign rdy_s6 = !v_s6 || out_ready;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign query_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= query_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	logic signed [EW-1:0]   e1_s1 [3];
	logic signed [EW-1:0]   e2_s1 [3];
	logic signed [EW-1:0]   d_s1  [3];
	logic signed [NW-1:0]   n_s2  [3];
	logic signed [EW-1:0]   d_s2  [3];
	logic signed [PW-1:0]   pd_s3 [3];
	logic [2*H-1:0]         ll_s3 [3];
	logic [MW-1:0]          lh_s3 [3];
	logic [2*HW-1:0]        hh_s3 [3];
	logic                   deg_s3;
	logic signed [NUMW-1:0] num_s4;
	logic [SW-1:0]          s_s4;
	logic                   deg_s4;
	logic [2*AH-1:0]        all_s5;
	logic [AW-1:0]          alh_s5;
	logic [2*AHW-1:0]       ahh_s5;
	logic [SW-1:0]          s_s5;
	logic                   deg_s5;
	logic [RW-1:0]          r_s6;
	logic [SW-1:0]          s_s6;
	logic                   deg_s6;

	logic [MW-1:0]          nabs [3];
	logic [AW-1:0]          aabs;
	logic [SW-1:0]          sq   [3];
	logic [TW-1:0]          tsq;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nabs[i] = n_s2[i][NW-1] ? MW'(-n_s2[i]) : MW'(n_s2[i]);
			sq[i]   = (SW'(hh_s3[i]) << (2 * H)) + (SW'(lh_s3[i]) << (H + 1))
				+ SW'(ll_s3[i]);
		end
		aabs = num_s4[NUMW-1] ? AW'(-num_s4) : AW'(num_s4);
		tsq  = ((TW'(ahh_s5) << (2 * AH)) + (TW'(alh_s5) << (AH + 1)) + TW'(all_s5))
			<< (2 * FRAC);
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && query_valid) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= EW'(c[3 + i]) - EW'(c[i]);
				e2_s1[i] <= EW'(c[6 + i]) - EW'(c[i]);
				d_s1[i]  <= EW'(c[9 + i]) - EW'(c[i]);
			end
		end
		if (rdy_s2 && v_s1) begin
			n_s2[0] <= NW'(e1_s1[1]) * NW'(e2_s1[2]) - NW'(e1_s1[2]) * NW'(e2_s1[1]);
			n_s2[1] <= NW'(e1_s1[2]) * NW'(e2_s1[0]) - NW'(e1_s1[0]) * NW'(e2_s1[2]);
			n_s2[2] <= NW'(e1_s1[0]) * NW'(e2_s1[1]) - NW'(e1_s1[1]) * NW'(e2_s1[0]);
			d_s2    <= d_s1;
		end
		if (rdy_s3 && v_s2) begin
			for (int i = 0; i < 3; i++) begin
				pd_s3[i] <= PW'(n_s2[i]) * PW'(d_s2[i]);
				ll_s3[i] <= (2 * H)'(nabs[i][H-1:0]) * (2 * H)'(nabs[i][H-1:0]);
				lh_s3[i] <= MW'(nabs[i][H-1:0]) * MW'(nabs[i][MW-1:H]);
				hh_s3[i] <= (2 * HW)'(nabs[i][MW-1:H]) * (2 * HW)'(nabs[i][MW-1:H]);
			end
			deg_s3 <= (n_s2[0] == '0) && (n_s2[1] == '0) && (n_s2[2] == '0);
		end
		if (rdy_s4 && v_s3) begin
			num_s4 <= NUMW'(pd_s3[0]) + NUMW'(pd_s3[1]) + NUMW'(pd_s3[2]);
			s_s4   <= sq[0] + sq[1] + sq[2];
			deg_s4 <= deg_s3;
		end
		if (rdy_s5 && v_s4) begin
			all_s5 <= (2 * AH)'(aabs[AH-1:0]) * (2 * AH)'(aabs[AH-1:0]);
			alh_s5 <= AW'(aabs[AH-1:0]) * AW'(aabs[AW-1:AH]);
			ahh_s5 <= (2 * AHW)'(aabs[AW-1:AH]) * (2 * AHW)'(aabs[AW-1:AH]);
			s_s5   <= s_s4;
			deg_s5 <= deg_s4;
		end
		if (rdy_s6 && v_s5) begin
			r_s6   <= RW'(tsq);
			s_s6   <= s_s5;
			deg_s6 <= deg_s5;
		end
	end

	assign out_valid = v_s6;
	assign out_r     = r_s6;
	assign out_s     = s_s6;
	assign out_degen = deg_s6;

endmodule

// ----- rtl/core/ptpd_cell.sv -----
// One square-root cell: decides one bit of the distance from the running remainder.
module ptpd_cell #(
	parameter int BIT = 0,
	parameter int SW  = 68,
	parameter int RW  = 121,
	parameter int YW  = 93,
	parameter int QW  = 25
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [RW-1:0] in_r,
	input  logic [YW-1:0] in_y,
	input  logic [SW-1:0] in_s,
	input  logic [QW-1:0] in_q,
	input  logic          in_degen,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [RW-1:0] out_r,
	output logic [YW-1:0] out_y,
	output logic [SW-1:0] out_s,
	output logic [QW-1:0] out_q,
	output logic          out_degen
);

	logic          v_q;
	logic [RW-1:0] r_q;
	logic [YW-1:0] y_q;
	logic [SW-1:0] s_q;
	logic [QW-1:0] q_q;
	logic          deg_q;

	// (q + 2^b)^2 * S - q^2 * S, with y = q * S
	logic [RW-1:0] delta;
	logic          take;

	assign delta = (RW'(in_y) << (BIT + 1)) + (RW'(in_s) << (2 * BIT));
	assign take  = delta <= in_r;

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			r_q   <= take ? in_r - delta : in_r;
			y_q   <= take ? in_y + (YW'(in_s) << BIT) : in_y;
			q_q   <= take ? (in_q | (QW'(1) << BIT)) : in_q;
			s_q   <= in_s;
			deg_q <= in_degen;
		end
	end

	assign out_valid = v_q;
	assign out_r     = r_q;
	assign out_y     = y_q;
	assign out_s     = s_q;
	assign out_q     = q_q;
	assign out_degen = deg_q;

endmodule

// ----- rtl/core/point_to_plane_distance.sv -----
// Top level: front arithmetic pipeline followed by a chain of square-root cells.
// Distance from a query point to the plane through three points, as unsigned fixed
// point with FRAC_BITS fraction bits, truncated and saturated to 25 bits. One item
// enters per cycle and one result leaves per cycle when the output is not stalled.
// Six front stages form the normal, the plane numerator and its square; each of the
// 25 cells then settles one result bit with one wide subtract and compare. Collinear
// plane points give degenerate = 1 and distance 0. Every stage has its own valid
// bit, so bubbles close up under stall.
module point_to_plane_distance #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                query_valid,
	output logic                query_ready,
	input  ptpd_pkg::ptpd_in_t  query,
	output logic                result_valid,
	input  logic                result_ready,
	output ptpd_pkg::ptpd_out_t result
);

	localparam int QW   = ptpd_pkg::DIST_W;
	localparam int NW   = 2 * COORD_WIDTH + 2;
	localparam int MW   = NW - 1;
	localparam int SW   = 2 * MW + 2;
	localparam int NUMW = NW + COORD_WIDTH + 3;
	localparam int AW   = NUMW - 1;
	localparam int TW   = 2 * AW + 2 * FRAC_BITS;
	localparam int DMAX = SW + 2 * QW;
	localparam int RW   = ((TW > DMAX) ? TW : DMAX) + 1;
	localparam int YW   = SW + QW;

	logic          v_c   [QW+1];
	logic          rdy_c [QW+1];
	logic [RW-1:0] r_c   [QW+1];
	logic [YW-1:0] y_c   [QW+1];
	logic [SW-1:0] s_c   [QW+1];
	logic [QW-1:0] q_c   [QW+1];
	logic          deg_c [QW+1];

	ptpd_front #(
		.CW   (COORD_WIDTH),
		.FRAC (FRAC_BITS),
		.SW   (SW),
		.RW   (RW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.query_valid (query_valid),
		.query_ready (query_ready),
		.query       (query),
		.out_valid   (v_c[0]),
		.out_ready   (rdy_c[0]),
		.out_r       (r_c[0]),
		.out_s       (s_c[0]),
		.out_degen   (deg_c[0])
	);

	assign y_c[0] = '0;
	assign q_c[0] = '0;

	for (genvar k = 0; k < QW; k++) begin : g_cell
		ptpd_cell #(
			.BIT (QW - 1 - k),
			.SW  (SW),
			.RW  (RW),
			.YW  (YW),
			.QW  (QW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_c[k]),
			.in_ready  (rdy_c[k]),
			.in_r      (r_c[k]),
			.in_y      (y_c[k]),
			.in_s      (s_c[k]),
			.in_q      (q_c[k]),
			.in_degen  (deg_c[k]),
			.out_valid (v_c[k+1]),
			.out_ready (rdy_c[k+1]),
			.out_r     (r_c[k+1]),
			.out_y     (y_c[k+1]),
			.out_s     (s_c[k+1]),
			.out_q     (q_c[k+1]),
			.out_degen (deg_c[k+1])
		);
	end

	assign rdy_c[QW]             = result_ready;
	assign result_valid          = v_c[QW];
	assign result.degenerate     = deg_c[QW];
	// zero normal leaves a zero remainder, so the cells would saturate: force 0
	assign result.distance_fixed = deg_c[QW] ? '0 : q_c[QW];

`ifndef SYNTHESIS
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.degenerate |-> result.distance_fixed == '0)
		else $error("degenerate item with nonzero distance");

	a_degen_num: assert property (@(posedge clk) disable iff (!arst_n)
		v_c[0] && deg_c[0] |-> r_c[0] == '0 && s_c[0] == '0)
		else $error("zero normal with nonzero numerator or norm");

	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		result_ready |-> query_ready)
		else $error("input stalled while output drains");
`endif

endmodule
